@@ rtl/xxh32_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xxh32_pkg
// Shared constants, types and helpers for the streaming xxHash32 block.
// ----------------------------------------------------------------------------
package xxh32_pkg;

  localparam logic [31:0] P1 = 32'd2654435761;
  localparam logic [31:0] P2 = 32'd2246822519;
  localparam logic [31:0] P3 = 32'd3266489917;
  localparam logic [31:0] P4 = 32'd668265263;
  localparam logic [31:0] P5 = 32'd374761393;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned LaneIdxW  = 2;
  localparam int unsigned FillW     = 4;
  localparam logic [FillW-1:0] LastFill = 4'd15;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LMUL,
    S_LADD,
    S_LFIN,
    S_HINIT,
    S_HTOT,
    S_WMUL,
    S_WADD,
    S_WFIN,
    S_BLOAD,
    S_BMUL,
    S_BADD,
    S_BFIN,
    S_AV1,
    S_AV2,
    S_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LMUL,   // m = word[idx] * P2
    OP_LADD,   // t = rotl(acc[idx] + m, 13)
    OP_LFIN,   // acc[idx] = t * P1
    OP_HINIT,  // h = merged lanes or seed + P5
    OP_HTOT,   // h += byte total
    OP_WMUL,   // m = word[idx] * P3
    OP_WADD,   // t = rotl(h + m, 17)
    OP_WFIN,   // h = t * P4
    OP_BLOAD,  // w = word[idx]
    OP_BMUL,   // m = w[7:0] * P5
    OP_BADD,   // t = rotl(h + m, 11)
    OP_BFIN,   // h = t * P1, next byte of w
    OP_AV1,    // h = (h ^ h >> 15) * P2
    OP_AV2,    // h = (h ^ h >> 13) * P3
    OP_OUT     // hash = h ^ h >> 16, restart message
  } dp_op_e;

  typedef struct packed {
    logic                accept;
    dp_op_e              op;
    logic [LaneIdxW-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
    logic             out_free;
  } dp_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage
`default_nettype wire

@@ rtl/xxhash32_stream.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xxhash32_stream
// Streaming xxHash32 over a byte stream with a configurable seed.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the block is idle. The byte that completes
// a 16-byte stripe is followed by the four lane rounds, which share one 32x32
// multiplier. An item with last set then runs the lane merge or seed init, the
// length add, a round per tail word and per tail byte, and the avalanche and
// result load, before the block takes the next item. The hash
// sits in an output register, so a new message can start while it waits;
// the next message's result load then holds, with the input blocked, until
// that register is free.
// A seed write restarts the message in progress.
module xxhash32_stream (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      hash_value_o
);

  xxh32_pkg::dp_cmd_t cmd;
  xxh32_pkg::dp_sts_t sts;

  xxh32_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .has_byte_i (has_byte_i),
    .last_i     (last_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  xxh32_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .data_byte_i  (data_byte_i),
    .has_byte_i   (has_byte_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

endmodule
`default_nettype wire

@@ rtl/xxh32_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xxh32_dp
// Datapath: lanes, stripe buffer, counters, shared multiplier and result reg.
// ----------------------------------------------------------------------------
module xxh32_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [31:0]       cfg_wdata_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              has_byte_i,
  input  wire xxh32_pkg::dp_cmd_t cmd_i,
  output xxh32_pkg::dp_sts_t     sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [31:0]            hash_value_o
);

  logic [31:0] seed_q;
  logic [31:0] acc_q [xxh32_pkg::NumLanes];
  logic [31:0] buf_q [xxh32_pkg::NumLanes];
  logic [xxh32_pkg::FillW-1:0] fill_q;
  logic [31:0] total_q;
  logic        long_q;
  logic        out_valid_q;
  logic [31:0] hash_q;
  logic [31:0] m_q, t_q, h_q, w_q;

  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] add_a, sum;
  logic [31:0] merge;
  logic [31:0] word_sel;
  logic        restart;
  logic        wr_byte;

  assign word_sel = buf_q[cmd_i.idx];
  assign prod     = mul_a * mul_b;
  assign sum      = add_a + m_q;
  assign merge    = xxh32_pkg::rotl(acc_q[0], 1)  + xxh32_pkg::rotl(acc_q[1], 7)
                  + xxh32_pkg::rotl(acc_q[2], 12) + xxh32_pkg::rotl(acc_q[3], 18);
  assign restart  = (cmd_i.op == xxh32_pkg::OP_OUT);
  assign wr_byte  = cmd_i.accept && has_byte_i;

  always_comb begin
    mul_a = t_q;
    mul_b = xxh32_pkg::P1;
    case (cmd_i.op)
      xxh32_pkg::OP_LMUL: begin
        mul_a = word_sel;
        mul_b = xxh32_pkg::P2;
      end
      xxh32_pkg::OP_WMUL: begin
        mul_a = word_sel;
        mul_b = xxh32_pkg::P3;
      end
      xxh32_pkg::OP_WFIN: begin
        mul_a = t_q;
        mul_b = xxh32_pkg::P4;
      end
      xxh32_pkg::OP_BMUL: begin
        mul_a = {24'd0, w_q[7:0]};
        mul_b = xxh32_pkg::P5;
      end
      xxh32_pkg::OP_AV1: begin
        mul_a = h_q ^ (h_q >> 15);
        mul_b = xxh32_pkg::P2;
      end
      xxh32_pkg::OP_AV2: begin
        mul_a = h_q ^ (h_q >> 13);
        mul_b = xxh32_pkg::P3;
      end
      default: begin
        mul_a = t_q;
        mul_b = xxh32_pkg::P1;
      end
    endcase
  end

  always_comb begin
    add_a = (cmd_i.op == xxh32_pkg::OP_LADD) ? acc_q[cmd_i.idx] : h_q;
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      acc_q[0]    <= xxh32_pkg::P1 + xxh32_pkg::P2;
      acc_q[1]    <= xxh32_pkg::P2;
      acc_q[2]    <= '0;
      acc_q[3]    <= 32'd0 - xxh32_pkg::P1;
      fill_q      <= '0;
      total_q     <= '0;
      long_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        seed_q   <= cfg_wdata_i;
        acc_q[0] <= cfg_wdata_i + xxh32_pkg::P1 + xxh32_pkg::P2;
        acc_q[1] <= cfg_wdata_i + xxh32_pkg::P2;
        acc_q[2] <= cfg_wdata_i;
        acc_q[3] <= cfg_wdata_i - xxh32_pkg::P1;
        fill_q   <= '0;
        total_q  <= '0;
        long_q   <= 1'b0;
      end else if (restart) begin
        acc_q[0]    <= seed_q + xxh32_pkg::P1 + xxh32_pkg::P2;
        acc_q[1]    <= seed_q + xxh32_pkg::P2;
        acc_q[2]    <= seed_q;
        acc_q[3]    <= seed_q - xxh32_pkg::P1;
        fill_q      <= '0;
        total_q     <= '0;
        long_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else begin
        if (wr_byte) begin
          fill_q  <= fill_q + 1'b1;  // wraps to zero on a full stripe
          total_q <= total_q + 32'd1;
          if (fill_q == xxh32_pkg::LastFill) begin
            long_q <= 1'b1;
          end
        end
        if (cmd_i.op == xxh32_pkg::OP_LFIN) begin
          acc_q[cmd_i.idx] <= prod;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (wr_byte) begin
      buf_q[fill_q[3:2]][8*fill_q[1:0] +: 8] <= data_byte_i;
    end
    case (cmd_i.op)
      xxh32_pkg::OP_LMUL,
      xxh32_pkg::OP_WMUL,
      xxh32_pkg::OP_BMUL:  m_q <= prod;
      xxh32_pkg::OP_LADD:  t_q <= xxh32_pkg::rotl(sum, 13);
      xxh32_pkg::OP_WADD:  t_q <= xxh32_pkg::rotl(sum, 17);
      xxh32_pkg::OP_BADD:  t_q <= xxh32_pkg::rotl(sum, 11);
      xxh32_pkg::OP_HINIT: h_q <= long_q ? merge : seed_q + xxh32_pkg::P5;
      xxh32_pkg::OP_HTOT:  h_q <= h_q + total_q;
      xxh32_pkg::OP_WFIN,
      xxh32_pkg::OP_AV1,
      xxh32_pkg::OP_AV2:   h_q <= prod;
      xxh32_pkg::OP_BLOAD: w_q <= word_sel;
      xxh32_pkg::OP_BFIN: begin
        h_q <= prod;
        w_q <= w_q >> 8;
      end
      xxh32_pkg::OP_OUT:   hash_q <= h_q ^ (h_q >> 16);
      default: ;
    endcase
  end

  assign sts_o.fill     = fill_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign hash_value_o   = hash_q;

endmodule
`default_nettype wire

@@ rtl/xxh32_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xxh32_ctrl
// Controller: sequences lane rounds, tail consumption and avalanche.
// ----------------------------------------------------------------------------
module xxh32_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               has_byte_i,
  input  wire logic               last_i,
  input  wire xxh32_pkg::dp_sts_t sts_i,
  output xxh32_pkg::dp_cmd_t      cmd_o
);

  xxh32_pkg::state_e state_q, state_d;
  logic [xxh32_pkg::LaneIdxW-1:0] idx_q, idx_d;
  logic [xxh32_pkg::FillW-1:0]    left_q, left_d;
  logic                           last_q, last_d;
  logic                           accept;

  // where to go once the word loop has used up what it can
  function automatic xxh32_pkg::state_e tail_next(input logic [xxh32_pkg::FillW-1:0] l);
    if (l >= 4'd4) begin
      tail_next = xxh32_pkg::S_WMUL;
    end else if (l != '0) begin
      tail_next = xxh32_pkg::S_BLOAD;
    end else begin
      tail_next = xxh32_pkg::S_AV1;
    end
  endfunction

  assign in_ready_o = (state_q == xxh32_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xxh32_pkg::S_IDLE;
      idx_q   <= '0;
      left_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      left_q  <= left_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    left_d       = left_q;
    last_d       = last_q;
    cmd_o.accept = accept;
    cmd_o.op     = xxh32_pkg::OP_NONE;
    cmd_o.idx    = idx_q;
    case (state_q)
      xxh32_pkg::S_IDLE: begin
        if (accept) begin
          if (has_byte_i && sts_i.fill == xxh32_pkg::LastFill) begin
            state_d = xxh32_pkg::S_LMUL;
            idx_d   = '0;
            last_d  = last_i;
          end else if (last_i) begin
            state_d = xxh32_pkg::S_HINIT;
          end
        end
      end
      xxh32_pkg::S_LMUL: begin
        cmd_o.op = xxh32_pkg::OP_LMUL;
        state_d  = xxh32_pkg::S_LADD;
      end
      xxh32_pkg::S_LADD: begin
        cmd_o.op = xxh32_pkg::OP_LADD;
        state_d  = xxh32_pkg::S_LFIN;
      end
      xxh32_pkg::S_LFIN: begin
        cmd_o.op = xxh32_pkg::OP_LFIN;
        idx_d    = idx_q + 1'b1;
        if (idx_q == xxh32_pkg::LaneIdxW'(xxh32_pkg::NumLanes - 1)) begin
          state_d = last_q ? xxh32_pkg::S_HINIT : xxh32_pkg::S_IDLE;
        end else begin
          state_d = xxh32_pkg::S_LMUL;
        end
      end
      xxh32_pkg::S_HINIT: begin
        cmd_o.op = xxh32_pkg::OP_HINIT;
        left_d   = sts_i.fill;
        idx_d    = '0;
        state_d  = xxh32_pkg::S_HTOT;
      end
      xxh32_pkg::S_HTOT: begin
        cmd_o.op = xxh32_pkg::OP_HTOT;
        state_d  = tail_next(left_q);
      end
      xxh32_pkg::S_WMUL: begin
        cmd_o.op = xxh32_pkg::OP_WMUL;
        state_d  = xxh32_pkg::S_WADD;
      end
      xxh32_pkg::S_WADD: begin
        cmd_o.op = xxh32_pkg::OP_WADD;
        state_d  = xxh32_pkg::S_WFIN;
      end
      xxh32_pkg::S_WFIN: begin
        cmd_o.op = xxh32_pkg::OP_WFIN;
        idx_d    = idx_q + 1'b1;
        left_d   = left_q - 4'd4;
        state_d  = tail_next(left_q - 4'd4);
      end
      xxh32_pkg::S_BLOAD: begin
        cmd_o.op = xxh32_pkg::OP_BLOAD;
        state_d  = xxh32_pkg::S_BMUL;
      end
      xxh32_pkg::S_BMUL: begin
        cmd_o.op = xxh32_pkg::OP_BMUL;
        state_d  = xxh32_pkg::S_BADD;
      end
      xxh32_pkg::S_BADD: begin
        cmd_o.op = xxh32_pkg::OP_BADD;
        state_d  = xxh32_pkg::S_BFIN;
      end
      xxh32_pkg::S_BFIN: begin
        cmd_o.op = xxh32_pkg::OP_BFIN;
        left_d   = left_q - 4'd1;
        state_d  = (left_q == 4'd1) ? xxh32_pkg::S_AV1 : xxh32_pkg::S_BMUL;
      end
      xxh32_pkg::S_AV1: begin
        cmd_o.op = xxh32_pkg::OP_AV1;
        state_d  = xxh32_pkg::S_AV2;
      end
      xxh32_pkg::S_AV2: begin
        cmd_o.op = xxh32_pkg::OP_AV2;
        state_d  = xxh32_pkg::S_OUT;
      end
      xxh32_pkg::S_OUT: begin
        // hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.op = xxh32_pkg::OP_OUT;
          state_d  = xxh32_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = xxh32_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/xxh32_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xxh32_checker
// Port-level checks for xxhash32_stream, bound to the top level.
// ----------------------------------------------------------------------------
module xxh32_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        last_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] hash_value_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_value_o))
    else $error("result dropped or changed while stalled");

  // finishing a message always takes the block off the input side
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |=> !in_ready_o)
    else $error("input accepted right after a last item");

  // a new result appears only from the finishing sequence
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a finishing sequence");

  // a fresh result never replaces one still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && !in_ready_o |=> $stable(hash_value_o))
    else $error("pending result overwritten");

endmodule

bind xxhash32_stream xxh32_checker u_xxh32_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .last_i       (last_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hash_value_o (hash_value_o)
);
`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for xxhash32_stream. Random byte messages go in over
// valid/ready with random gaps and output stalls. A scoreboard recomputes
// each hash under the current seed and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [31:0] PRIME1 = 32'd2654435761;
  localparam bit [31:0] PRIME2 = 32'd2246822519;
  localparam bit [31:0] PRIME3 = 32'd3266489917;
  localparam bit [31:0] PRIME4 = 32'd668265263;
  localparam bit [31:0] PRIME5 = 32'd374761393;

  localparam int unsigned StripeBytes  = 16;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned RandomItems  = 550;
  localparam int unsigned NumPhases    = 6;

  class hash_tracker;
    bit [31:0]   seed;
    bit [31:0]   lane[4];
    bit [7:0]    stripe[StripeBytes];
    int unsigned fill;
    bit [31:0]   total;
    bit          long_msg;
    bit [31:0]   hashes_due[$];
    int unsigned errors;

    function new();
      seed   = '0;
      errors = 0;
      restart();
    endfunction

    function bit [31:0] rol(bit [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    // little-endian word from the stripe
    function bit [31:0] word_from(int unsigned pos);
      return {stripe[pos + 3], stripe[pos + 2], stripe[pos + 1], stripe[pos]};
    endfunction

    function bit [31:0] lane_step(bit [31:0] acc, bit [31:0] w);
      acc += w * PRIME2;
      return rol(acc, 13) * PRIME1;
    endfunction

    function void restart();
      lane[0]  = seed + PRIME1 + PRIME2;
      lane[1]  = seed + PRIME2;
      lane[2]  = seed;
      lane[3]  = seed - PRIME1;
      fill     = 0;
      total    = '0;
      long_msg = 1'b0;
    endfunction

    function void set_seed(bit [31:0] v);
      seed = v;
      restart();
    endfunction

    function bit [31:0] digest();
      bit [31:0]   h;
      int unsigned pos;
      int unsigned left;
      pos  = 0;
      left = fill;
      if (long_msg) begin
        h = rol(lane[0], 1) + rol(lane[1], 7) + rol(lane[2], 12) + rol(lane[3], 18);
      end else begin
        h = seed + PRIME5;
      end
      h += total;
      while (left >= 4) begin
        h += word_from(pos) * PRIME3;
        h = rol(h, 17) * PRIME4;
        pos += 4;
        left -= 4;
      end
      while (left > 0) begin
        h += {24'd0, stripe[pos]} * PRIME5;
        h = rol(h, 11) * PRIME1;
        pos++;
        left--;
      end
      h ^= h >> 15;
      h *= PRIME2;
      h ^= h >> 13;
      h *= PRIME3;
      h ^= h >> 16;
      return h;
    endfunction

    function void note_item(bit [7:0] d, bit has, bit fin);
      int unsigned i;
      if (has) begin
        stripe[fill] = d;
        fill++;
        total++;
        if (fill == StripeBytes) begin
          for (i = 0; i < 4; i++) lane[i] = lane_step(lane[i], word_from(4 * i));
          fill     = 0;
          long_msg = 1'b1;
        end
      end
      if (fin) begin
        hashes_due.push_back(digest());
        restart();
      end
    endfunction

    function void check_hash(bit [31:0] got);
      bit [31:0] want;
      if (hashes_due.size() == 0) begin
        $display("%0t: unexpected hash, expected none, got %08h", $time, got);
        errors++;
      end else begin
        want = hashes_due.pop_front();
        if (want != got) begin
          $display("%0t: hash mismatch, expected %08h, got %08h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return hashes_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        has_byte_i  = 1'b0;
  logic        last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] hash_value_o;

  hash_tracker tracker = new();
  bit          quiet = 1'b0;
  int unsigned sent_items = 0;

  xxhash32_stream dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .has_byte_i   (has_byte_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned sender_gap();
    if (quiet || $urandom_range(0, 2) != 0) return 0;
    return pick_gap();
  endfunction

  function automatic bit [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 20);
    if (r < 95) return $urandom_range(21, 48);
    return $urandom_range(49, 80);
  endfunction

  // alternate busy and calm stretches for both sides
  initial begin
    forever begin
      repeat ($urandom_range(60, 400)) @(posedge clk_i);
      quiet = ~quiet;
    end
  end

  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) tracker.check_hash(hash_value_o);
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall = pick_gap() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // called at a clock edge; valid stays up after the item is taken
  task automatic send_item(bit [7:0] d, bit has, bit fin);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    has_byte_i  <= has;
    last_i      <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_item(d, has, fin);
  endtask

  task automatic send_message(int unsigned len);
    int unsigned k;
    bit          split_end;
    split_end = (len == 0) || ($urandom_range(0, 2) == 0);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) send_item(pick_byte(), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, (k == len - 1) && !split_end);
      sent_items++;
    end
    if (split_end) begin
      send_item(pick_byte(), 1'b0, 1'b1);
      sent_items++;
    end
  endtask

  // message left open; the next seed write drops it
  task automatic send_partial(int unsigned len);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      send_item(pick_byte(), 1'b1, 1'b0);
      sent_items++;
    end
  endtask

  // hold off until every hash is out and the block has gone quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(bit [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    tracker.set_seed(v);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned i;
    int unsigned phase;
    bit [31:0]   seeds[NumPhases];

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset seed, empty message, idle item, single bytes,
    // one word closed by an empty last, one full stripe
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'hFE, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    for (i = 0; i < StripeBytes; i++) send_item(8'(i * 8'h11), 1'b1, i == StripeBytes - 1);

    seeds = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h0000_0001,
              32'h8000_0000, $urandom};
    sent_items = 0;
    for (phase = 0; phase < NumPhases; phase++) begin
      if (phase == 0 || $urandom_range(0, 1) == 1) send_partial($urandom_range(1, 35));
      drain();
      write_seed(seeds[phase]);
      while (sent_items < (phase + 1) * RandomItems / NumPhases) send_message(pick_len());
    end
    drain();

    if (tracker.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
